### hw/rtl/stww_pkg.sv
// Shared types and constants for the styled text word wrap block.
`timescale 1ns / 1ps

package stww_pkg;

    localparam int WRAP_W  = 7;
    localparam int GLYPH_W = 32;
    localparam int LEN_W   = 3;
    localparam int COLOR_W = 32;

    localparam logic [7:0]       SPACE_CHAR = 8'h20;
    localparam logic [LEN_W-1:0] LEN_MIN    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_MAX    = 3'd4;

    // One buffered cell, normalized at intake
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               bold;
        logic               space;
    } cell_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS,
        ST_RD,
        ST_EMIT,
        ST_MARK,
        ST_MOVE_RD,
        ST_MOVE_WR
    } state_t;

endpackage

### hw/rtl/styled_text_word_wrap.sv
// Styled text word wrap: line buffer, break sequencer and output register.
// No-break cell: transfer, then store into the line buffer. Pass-through cell: transfer and
// break decision, then the output register is loaded. A line of L cells: each cell needs a
// registered RAM read and then an output load (an empty line sends one marker instead), then
// each carried tail cell is moved by a read and a write; an output stall holds the sequencer.
// Reset (aresetn low, synchronous) empties the buffer and sets the wrap width to zero.
`timescale 1ns / 1ps

module styled_text_word_wrap #(
    parameter int MAX_COLS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stww_pkg::WRAP_W-1:0]     cfg_wrap_width,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [stww_pkg::GLYPH_W-1:0]    s_glyph_bytes,
    input  logic [stww_pkg::LEN_W-1:0]      s_glyph_len,
    input  logic [stww_pkg::COLOR_W-1:0]    s_fore_color,
    input  logic [stww_pkg::COLOR_W-1:0]    s_back_color,
    input  logic                            s_bold_flag,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_cell_valid,
    output logic [stww_pkg::GLYPH_W-1:0]    m_out_glyph,
    output logic [stww_pkg::LEN_W-1:0]      m_out_len,
    output logic [stww_pkg::COLOR_W-1:0]    m_out_fore,
    output logic [stww_pkg::COLOR_W-1:0]    m_out_back,
    output logic                            m_out_bold,
    output logic                            m_line_end,
    output logic                            m_last_of_burst
);

    import stww_pkg::*;

    localparam int DEPTH = MAX_COLS + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // Line buffer
    cell_t mem [0:DEPTH-1];
    cell_t rd_data_reg;

    // Control state
    state_t              state_reg, state_next;
    logic [WRAP_W-1:0]   wrap_reg, wrap_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic                seen_reg, seen_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers
    cell_t               cell_reg, cell_next;
    logic                action_reg, action_next;
    logic [CW-1:0]       line_len_reg, line_len_next;
    logic [IW-1:0]       move_src_reg, move_src_next;
    logic [CW-1:0]       move_cnt_reg, move_cnt_next;
    logic [CW-1:0]       idx_reg, idx_next;
    cell_t               out_cell_reg, out_cell_next;
    logic                out_cv_reg, out_cv_next;
    logic                out_le_reg, out_le_next;
    logic                out_last_reg, out_last_next;

    // Memory ports
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    cell_t               mem_wdata;
    logic [IW-1:0]       rd_addr;

    // Helpers
    cell_t               in_cell;
    logic [LEN_W-1:0]    in_len;
    logic [WRAP_W-1:0]   w_eff;
    logic                w_zero;
    logic [CW-1:0]       fill_clamp;
    logic [CW-1:0]       n_cnt;
    logic [CW-1:0]       pos_plus;
    logic                over;
    logic                soft_brk;
    logic [CW-1:0]       ld_line_len;
    logic [CW-1:0]       ld_move_cnt;
    logic [IW-1:0]       ld_move_src;
    logic [CW-1:0]       idx_inc;
    logic                out_free;
    logic                emit_last;
    logic                move_last;

    assign cfg_ready = 1'b1;

    // Normalize the incoming cell: clamp length, clear bytes past it
    always_comb begin
        in_len = s_glyph_len;
        if (s_glyph_len < LEN_MIN) begin
            in_len = LEN_MIN;
        end else if (s_glyph_len > LEN_MAX) begin
            in_len = LEN_MAX;
        end
        in_cell.glyph = s_glyph_bytes;
        case (in_len)
            3'd1:    in_cell.glyph = {24'h0, s_glyph_bytes[7:0]};
            3'd2:    in_cell.glyph = {16'h0, s_glyph_bytes[15:0]};
            3'd3:    in_cell.glyph = {8'h0, s_glyph_bytes[23:0]};
            default: in_cell.glyph = s_glyph_bytes;
        endcase
        in_cell.len   = in_len;
        in_cell.fore  = s_fore_color;
        in_cell.back  = s_back_color;
        in_cell.bold  = s_bold_flag;
        in_cell.space = (in_len == LEN_MIN) && (s_glyph_bytes[7:0] == SPACE_CHAR);
    end

    // Break decision for the cell held in cell_reg
    always_comb begin
        w_eff      = (wrap_reg > WRAP_W'(MAX_COLS)) ? WRAP_W'(MAX_COLS) : wrap_reg;
        w_zero     = (w_eff == '0);
        fill_clamp = (fill_reg > CW'(MAX_COLS)) ? CW'(MAX_COLS) : fill_reg;
        n_cnt      = fill_clamp + CW'(1);
        pos_plus   = CW'(pos_reg) + CW'(1);
        over       = (WRAP_W'(n_cnt) > w_eff);
        soft_brk   = !cell_reg.space && seen_reg && (pos_plus < n_cnt);

        if (action_reg) begin
            ld_line_len = fill_reg;
            ld_move_cnt = '0;
            ld_move_src = '0;
        end else if (soft_brk) begin
            ld_line_len = CW'(pos_reg);
            ld_move_cnt = n_cnt - pos_plus;
            ld_move_src = pos_plus[IW-1:0];
        end else if (cell_reg.space) begin
            ld_line_len = fill_clamp;
            ld_move_cnt = '0;
            ld_move_src = '0;
        end else begin
            ld_line_len = fill_clamp;
            ld_move_cnt = CW'(1);
            ld_move_src = fill_clamp[IW-1:0];
        end

        idx_inc   = idx_reg + CW'(1);
        out_free  = !out_valid_reg || m_ready;
        emit_last = (idx_inc == line_len_reg);
        move_last = (idx_inc == move_cnt_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (action_reg || (!w_zero && over)) begin
                    state_next = (ld_line_len == '0) ? ST_MARK : ST_RD;
                end else if (w_zero) begin
                    state_next = ST_PASS;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (!emit_last) begin
                        state_next = ST_RD;
                    end else if (move_cnt_reg != '0) begin
                        state_next = ST_MOVE_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    state_next = (move_cnt_reg != '0) ? ST_MOVE_RD : ST_IDLE;
                end
            end
            ST_MOVE_RD: begin
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                state_next = move_last ? ST_IDLE : ST_MOVE_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready        = 1'b0;
        wrap_next      = cfg_valid ? cfg_wrap_width : wrap_reg;
        cell_next      = cell_reg;
        action_next    = action_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        line_len_next  = line_len_reg;
        move_src_next  = move_src_reg;
        move_cnt_next  = move_cnt_reg;
        idx_next       = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IW-1:0];
        mem_wdata      = rd_data_reg;
        rd_addr        = idx_reg[IW-1:0];
        out_valid_next = out_valid_reg && !m_ready;
        out_cell_next  = out_cell_reg;
        out_cv_next    = out_cv_reg;
        out_le_next    = out_le_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cell_next   = in_cell;
                    action_next = s_action;
                end
            end
            ST_LOAD: begin
                idx_next = '0;
                if (action_reg) begin
                    // flush the whole buffer as the last line
                    fill_next     = '0;
                    seen_next     = 1'b0;
                    pos_next      = '0;
                    line_len_next = ld_line_len;
                    move_cnt_next = '0;
                    move_src_next = '0;
                end else if (!w_zero) begin
                    mem_we    = 1'b1;
                    mem_waddr = fill_clamp[IW-1:0];
                    mem_wdata = cell_reg;
                    if (over) begin
                        fill_next     = ld_move_cnt;
                        seen_next     = 1'b0;
                        pos_next      = '0;
                        line_len_next = ld_line_len;
                        move_cnt_next = ld_move_cnt;
                        move_src_next = ld_move_src;
                    end else begin
                        fill_next = n_cnt;
                        if (cell_reg.space) begin
                            seen_next = 1'b1;
                            pos_next  = fill_clamp[IW-1:0];
                        end
                    end
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cell_reg;
                    out_cv_next    = 1'b1;
                    out_le_next    = 1'b0;
                    out_last_next  = 1'b1;
                end
            end
            ST_RD: begin
                rd_addr = idx_reg[IW-1:0];
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cell_next  = rd_data_reg;
                    out_cv_next    = 1'b1;
                    out_le_next    = emit_last;
                    out_last_next  = emit_last;
                    idx_next       = emit_last ? '0 : idx_inc;
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cell_next  = '0;
                    out_cv_next    = 1'b0;
                    out_le_next    = 1'b1;
                    out_last_next  = 1'b1;
                    idx_next       = '0;
                end
            end
            ST_MOVE_RD: begin
                rd_addr = move_src_reg + idx_reg[IW-1:0];
            end
            ST_MOVE_WR: begin
                // shift the carried tail down to the head of the buffer
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IW-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_inc;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Line buffer RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wrap_reg      <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wrap_reg      <= wrap_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cell_reg     <= cell_next;
        action_reg   <= action_next;
        line_len_reg <= line_len_next;
        move_src_reg <= move_src_next;
        move_cnt_reg <= move_cnt_next;
        idx_reg      <= idx_next;
        out_cell_reg <= out_cell_next;
        out_cv_reg   <= out_cv_next;
        out_le_reg   <= out_le_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_cell_valid    = out_cv_reg;
    assign m_out_glyph     = out_cell_reg.glyph;
    assign m_out_len       = out_cell_reg.len;
    assign m_out_fore      = out_cell_reg.fore;
    assign m_out_back      = out_cell_reg.back;
    assign m_out_bold      = out_cell_reg.bold;
    assign m_line_end      = out_le_reg;
    assign m_last_of_burst = out_last_reg;

`ifndef SYNTHESIS
    // buffer never holds more than a full line between items
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(MAX_COLS))
        else $error("line buffer fill above column limit");

    // a held space always lies inside the buffered cells
    a_space_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (CW'(pos_reg) < fill_reg))
        else $error("space position outside buffered cells");

    // emission index stays inside the line being sent
    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_RD) |-> (idx_reg < line_len_reg))
        else $error("emit index past line length");

    // an empty-line marker carries no cell and always closes the burst
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_cell_valid) |-> (m_line_end && m_last_of_burst && m_out_len == '0))
        else $error("malformed empty-line marker");

    // a burst ends on a line end unless the cell was passed straight through
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_burst && !m_line_end) |-> m_cell_valid)
        else $error("burst closed without line end on a marker");
`endif

endmodule

### tb/styled_text_word_wrap_tb.sv
// Testbench for styled_text_word_wrap: random and directed styled text against a line predictor.
`timescale 1ns / 1ps

module styled_text_word_wrap_tb;

    import stww_pkg::*;

    localparam int MAX_COLS     = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    // Longest internal work with no transfer: a carried tail moved by a read and a write per cell
    localparam int SETTLE_CYCLES = 2 * MAX_COLS + 16;
    localparam int HOLD_AFTER    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;

    typedef enum logic {ACT_CELL, ACT_END} action_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        action_t            action;
        logic [GLYPH_W-1:0] glyph;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               bold;
    } text_item_t;

    typedef struct packed {
        logic               cell_valid;
        logic [GLYPH_W-1:0] glyph;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               bold;
        logic               line_end;
        logic               last_of_burst;
    } wrap_out_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WRAP_W-1:0]   cfg_wrap_width = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_action = 1'b0;
    logic [GLYPH_W-1:0]  s_glyph_bytes = '0;
    logic [LEN_W-1:0]    s_glyph_len = '0;
    logic [COLOR_W-1:0]  s_fore_color = '0;
    logic [COLOR_W-1:0]  s_back_color = '0;
    logic                s_bold_flag = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_cell_valid;
    logic [GLYPH_W-1:0]  m_out_glyph;
    logic [LEN_W-1:0]    m_out_len;
    logic [COLOR_W-1:0]  m_out_fore;
    logic [COLOR_W-1:0]  m_out_back;
    logic                m_out_bold;
    logic                m_line_end;
    logic                m_last_of_burst;

    styled_text_word_wrap #(
        .MAX_COLS(MAX_COLS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_wrap_width(cfg_wrap_width),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_glyph_bytes(s_glyph_bytes),
        .s_glyph_len(s_glyph_len),
        .s_fore_color(s_fore_color),
        .s_back_color(s_back_color),
        .s_bold_flag(s_bold_flag),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_valid(m_cell_valid),
        .m_out_glyph(m_out_glyph),
        .m_out_len(m_out_len),
        .m_out_fore(m_out_fore),
        .m_out_back(m_out_back),
        .m_out_bold(m_out_bold),
        .m_line_end(m_line_end),
        .m_last_of_burst(m_last_of_burst)
    );

    // Clock
    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    text_item_t pending_q[$];
    wrap_out_t  wrapped_q[$];

    int items_queued = 0;
    int items_taken  = 0;
    int cells_out    = 0;
    int lines_out    = 0;
    int width_writes = 0;
    int mismatches   = 0;

    // Predicted line state
    cell_t             line_buf [0:MAX_COLS];
    int                line_fill = 0;
    int                space_at = 0;
    logic              space_held = 1'b0;
    logic [WRAP_W-1:0] wrap_setting = '0;

    function automatic wrap_out_t cell_result(cell_t c, logic le);
        wrap_out_t r;
        r = '0;
        r.cell_valid = 1'b1;
        r.glyph      = c.glyph;
        r.len        = c.len;
        r.fore       = c.fore;
        r.back       = c.back;
        r.bold       = c.bold;
        r.line_end   = le;
        return r;
    endfunction

    // Emit the first count buffered cells as one line, or an empty-line marker
    function automatic void predict_line(int count);
        wrap_out_t r;
        r = '0;
        if (count == 0) begin
            r.line_end = 1'b1;
            wrapped_q = {wrapped_q, r};
        end else begin
            for (int j = 0; j < count; j++)
                wrapped_q = {wrapped_q, cell_result(line_buf[j], j == count - 1)};
        end
    endfunction

    function automatic void rescan_spaces();
        space_held = 1'b0;
        space_at   = 0;
        for (int j = 0; j < line_fill; j++) begin
            if (line_buf[j].space) begin
                space_held = 1'b1;
                space_at   = j;
            end
        end
    endfunction

    // Work out the output cells that one accepted item causes
    function automatic void wrap_text_item(text_item_t it);
        cell_t     c;
        int        w;
        int        n;
        int        sp;
        logic      emitted;
        wrap_out_t tail;
        emitted = 1'b0;
        w = (wrap_setting > MAX_COLS) ? MAX_COLS : int'(wrap_setting);
        if (it.action == ACT_END) begin
            predict_line(line_fill);
            line_fill  = 0;
            space_held = 1'b0;
            space_at   = 0;
            emitted    = 1'b1;
        end else begin
            if (it.len < LEN_MIN)
                c.len = LEN_MIN;
            else if (it.len > LEN_MAX)
                c.len = LEN_MAX;
            else
                c.len = it.len;
            c.glyph = it.glyph & ({GLYPH_W{1'b1}} >> (8 * (LEN_MAX - c.len)));
            c.fore  = it.fore;
            c.back  = it.back;
            c.bold  = it.bold;
            c.space = (c.len == LEN_MIN) && (c.glyph[7:0] == SPACE_CHAR);
            if (w == 0) begin
                wrapped_q = {wrapped_q, cell_result(c, 1'b0)};
                emitted = 1'b1;
            end else begin
                if (line_fill > MAX_COLS)
                    line_fill = MAX_COLS;
                line_buf[line_fill] = c;
                line_fill++;
                if (c.space) begin
                    space_held = 1'b1;
                    space_at   = line_fill - 1;
                end
                n = line_fill;
                if (n > w) begin
                    if (space_held && space_at + 1 < n) begin
                        // soft break: head out, space dropped, tail carried
                        sp = space_at;
                        predict_line(sp);
                        for (int j = 0; j < n - sp - 1; j++)
                            line_buf[j] = line_buf[sp + 1 + j];
                        line_fill = n - sp - 1;
                    end else if (line_buf[n - 1].space) begin
                        // overflowing space: drop it, flush the rest
                        predict_line(n - 1);
                        line_fill = 0;
                    end else begin
                        // hard break: carry the newest cell
                        predict_line(n - 1);
                        line_buf[0] = line_buf[n - 1];
                        line_fill = 1;
                    end
                    rescan_spaces();
                    emitted = 1'b1;
                end
            end
        end
        if (emitted) begin
            tail = wrapped_q[wrapped_q.size() - 1];
            tail.last_of_burst = 1'b1;
            wrapped_q[wrapped_q.size() - 1] = tail;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: check output transfers, track config and input transfers
    wrap_out_t  exp_cell;
    text_item_t seen_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            wrap_setting = '0;
            line_fill    = 0;
            space_at     = 0;
            space_held   = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                cells_out++;
                if (m_line_end)
                    lines_out++;
                if (wrapped_q.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual glyph %h le %b",
                             $time, m_out_glyph, m_line_end);
                    mismatches++;
                end else begin
                    exp_cell = wrapped_q.pop_front();
                    check_field("cell_valid", 32'(exp_cell.cell_valid), 32'(m_cell_valid));
                    check_field("out_glyph", exp_cell.glyph, m_out_glyph);
                    check_field("out_len", 32'(exp_cell.len), 32'(m_out_len));
                    check_field("out_fore", exp_cell.fore, m_out_fore);
                    check_field("out_back", exp_cell.back, m_out_back);
                    check_field("out_bold", 32'(exp_cell.bold), 32'(m_out_bold));
                    check_field("line_end", 32'(exp_cell.line_end), 32'(m_line_end));
                    check_field("last_of_burst", 32'(exp_cell.last_of_burst),
                                32'(m_last_of_burst));
                end
            end
            if (cfg_valid && cfg_ready) begin
                wrap_setting = cfg_wrap_width;
                width_writes++;
            end
            if (s_valid && s_ready) begin
                seen_item.action = action_t'(s_action);
                seen_item.glyph  = s_glyph_bytes;
                seen_item.len    = s_glyph_len;
                seen_item.fore   = s_fore_color;
                seen_item.back   = s_back_color;
                seen_item.bold   = s_bold_flag;
                wrap_text_item(seen_item);
                items_taken++;
            end
        end
    end

    // Driver: bursts of items from the pending queue with random gaps
    text_item_t cur_item;
    int         burst_left = 8;
    int         gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                cur_item = pending_q.pop_front();
                s_valid       <= 1'b1;
                s_action      <= cur_item.action;
                s_glyph_bytes <= cur_item.glyph;
                s_glyph_len   <= cur_item.len;
                s_fore_color  <= cur_item.fore;
                s_back_color  <= cur_item.back;
                s_bold_flag   <= cur_item.bold;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 5) == 0) begin
                        // long stretch with no idling
                        burst_left = $urandom_range(30, 60);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 10);
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern in segments, plus one long hold-off
    rx_mode_t rx_mode = RX_OPEN;
    int       seg_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    int       rx_seen = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rx_seen++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && rx_seen >= HOLD_AFTER && s_valid) begin
                // hold off while the sender keeps offering, so the block backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 80);
                    rx_mode  = rx_mode_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                    default:   m_ready <= (seg_left % 4 == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d output cells still expected", $time, wrapped_q.size());
                $display("styled_text_word_wrap test failed");
                $finish;
            end
        end
    end

    task automatic queue_item(action_t act, logic [GLYPH_W-1:0] g, logic [LEN_W-1:0] l,
                              logic [COLOR_W-1:0] f, logic [COLOR_W-1:0] b, logic bo);
        text_item_t it;
        it.action = act;
        it.glyph  = g;
        it.len    = l;
        it.fore   = f;
        it.back   = b;
        it.bold   = bo;
        pending_q = {pending_q, it};
        items_queued++;
    endtask

    // End of text, with junk in the unused fields
    task automatic queue_end();
        queue_item(ACT_END, $urandom, 3'($urandom_range(0, 7)), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
    endtask

    task automatic queue_space();
        logic [GLYPH_W-1:0] g;
        g = $urandom;
        g[7:0] = SPACE_CHAR;
        queue_item(ACT_CELL, g, LEN_MIN, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // ASCII cells with garbage above the first byte
    task automatic queue_ascii(string s);
        logic [GLYPH_W-1:0] g;
        for (int i = 0; i < s.len(); i++) begin
            g = $urandom;
            g[7:0] = s[i];
            queue_item(ACT_CELL, g, LEN_MIN, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    // One word in one style; no cell is a space
    task automatic queue_word(int count);
        logic [COLOR_W-1:0] f;
        logic [COLOR_W-1:0] b;
        logic               bo;
        logic [GLYPH_W-1:0] g;
        logic [LEN_W-1:0]   l;
        f  = $urandom;
        b  = $urandom;
        bo = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            l = 3'($urandom_range(1, 4));
            g = $urandom;
            if (l == LEN_MIN)
                g[7:0] = 8'($urandom_range(33, 126));
            queue_item(ACT_CELL, g, l, f, b, bo);
        end
    endtask

    task automatic queue_noise();
        queue_item(action_t'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)),
                   $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Mostly words and spaces, some long words, end items and raw noise
    task automatic queue_text(int count, int max_word);
        int stop_at;
        int pick;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                queue_word($urandom_range(1, max_word));
                queue_space();
            end else if (pick < 72) begin
                queue_word($urandom_range(max_word, 2 * max_word + 2));
            end else if (pick < 82) begin
                queue_space();
            end else if (pick < 90) begin
                queue_end();
            end else begin
                queue_noise();
            end
        end
    endtask

    // Write the wrap width while the block is idle
    task automatic set_width(logic [WRAP_W-1:0] w);
        @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_wrap_width <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for every queued item and expected cell, then for internal work to settle
    task automatic drain();
        do @(negedge aclk); while (pending_q.size() != 0 || s_valid || wrapped_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Pass-through at the reset width: bad lengths, all-ones fields, closing marker
        queue_item(ACT_CELL, 32'hDEADBE41, 3'd0, '0, '0, 1'b0);
        queue_item(ACT_CELL, '1, 3'd7, '1, '1, 1'b1);
        queue_end();
        drain();

        // Width 2: soft break, overflowing space, empty head, hard break, empty flush
        set_width(7'd2);
        queue_ascii("a bc");
        queue_item(ACT_CELL, 32'h5A5A5A20, LEN_MIN, $urandom, $urandom, 1'b1);
        queue_ascii(" xyz");
        queue_end();
        queue_end();
        drain();

        // Shrink the width under a held line, then switch to pass-through with cells held
        set_width(7'd20);
        queue_ascii("a bcdef");
        drain();
        set_width(7'd2);
        queue_ascii("gh");
        drain();
        set_width(7'd0);
        queue_ascii("x");
        queue_end();
        drain();

        // Random text at several widths
        set_width(7'd1);
        queue_text(5, 3);
        queue_end();
        drain();

        set_width(7'($urandom_range(3, 12)));
        queue_text(8, 8);
        queue_end();
        drain();

        set_width(7'd64);
        queue_text(6, 10);
        queue_end();
        drain();

        // Saturated width: one unbroken word fills the widest line and forces a hard break
        set_width(7'd127);
        queue_word(MAX_COLS + 1);
        queue_text(2, 6);
        queue_end();
        drain();

        set_width(7'd0);
        queue_text(4, 5);
        queue_end();
        drain();

        $display("Run covered %0d input items, %0d output cells in %0d lines, %0d width writes,",
                 items_taken, cells_out, lines_out, width_writes);
        $display("widths 0, 1, 2, 20, 64 and 127, width changes with a held line, one long stall.");
        if (mismatches == 0 && wrapped_q.size() == 0)
            $display("styled_text_word_wrap test passed");
        else
            $display("styled_text_word_wrap test failed");
        $finish;
    end

endmodule
